[sv/sha256_pkg.sv]
// Package: shared types, constants and round functions for the single-block SHA-256 hasher.
package sha256_pkg;

  localparam int unsigned MaxBytes = 55;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       no_byte;
    logic       last;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        too_long;
  } sha_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_INIT,
    ST_ROUND,
    ST_EMIT
  } sha_state_e;

  typedef struct packed {
    logic store_item;
    logic load_word;
    logic init_vars;
    logic do_round;
    logic emit_word;
    logic clear_msg;
    logic [5:0] step;
  } sha_cmd_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction

endpackage

[sv/sha256_ram.sv]
// Generic RAM with one write port, one read port and registered read.
module sha256_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[sv/sha256_ctrl.sv]
// Controller: sequences byte intake, block load, rounds and digest output.
module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  sha_in_t  item_i,
  output logic     busy_o,
  output sha_cmd_t cmd_o
);
  sha_state_e state_q, state_d;
  logic [5:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.step = step_q;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.store_item = 1'b1;
          if (item_i.last) begin
            state_d = ST_LOAD;
            step_d  = '0;
          end
        end
      end
      ST_LOAD: begin
        // one byte per cycle: RAM read addressed at step, written next cycle
        cmd_o.load_word = 1'b1;
        step_d = step_q + 6'd1;
        if (step_q == 6'd63) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init_vars = 1'b1;
        step_d  = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.do_round = 1'b1;
        step_d = step_q + 6'd1;
        if (step_q == 6'd63) begin
          state_d = ST_EMIT;
          step_d  = '0;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_word = 1'b1;
        step_d = step_q + 6'd1;
        if (step_q == 6'd7) begin
          cmd_o.clear_msg = 1'b1;
          state_d = ST_IDLE;
          step_d  = '0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

[sv/sha256_dp.sv]
// Datapath: message store, padding, schedule window, round logic and digest.
module sha256_dp
  import sha256_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sha_in_t  item_i,
  input  sha_cmd_t cmd_i,
  output logic     result_valid_o,
  output sha_out_t result_o
);
  logic [5:0]  count_q;
  logic        ovf_q;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [7:0]  ram_rdata;
  logic [5:0]  ram_raddr;
  logic        ram_we;
  logic [5:0]  load_pos_q;
  logic        load_act_q;
  logic [7:0]  pad_byte;
  logic [63:0] bit_len;

  assign ram_we    = cmd_i.store_item && !item_i.no_byte && (count_q < 6'(MaxBytes));
  assign ram_raddr = cmd_i.step;

  sha256_ram #(.Width(8), .Depth(64)) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q),
    .wdata_i (item_i.data_byte),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign bit_len = {55'd0, count_q, 3'd0};

  always_comb begin
    if (load_pos_q < count_q) begin
      pad_byte = ram_rdata;
    end else if (load_pos_q == count_q) begin
      pad_byte = PadByte;
    end else if (load_pos_q >= 6'd56) begin
      pad_byte = bit_len[{3'd7 - load_pos_q[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'd0;
    end
  end

  logic [31:0] w2, w7, w15, w16, s0, s1, wnew, wcur;
  logic [31:0] t1, t2, ch, maj, e1, e0;
  logic [3:0]  slot;

  assign slot = cmd_i.step[3:0];
  assign w2   = w_q[4'(slot - 4'd2)];
  assign w7   = w_q[4'(slot - 4'd7)];
  assign w15  = w_q[4'(slot - 4'd15)];
  assign w16  = w_q[slot];
  assign s1   = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
  assign s0   = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
  assign wnew = s1 + w7 + s0 + w16;
  assign wcur = (cmd_i.step >= 6'd16) ? wnew : w16;
  assign e1   = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign e0   = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1   = v_q[7] + e1 + ch + RoundK[cmd_i.step] + wcur;
  assign t2   = e0 + maj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      ovf_q          <= 1'b0;
      load_act_q     <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      load_act_q     <= cmd_i.load_word;
      result_valid_o <= cmd_i.emit_word;
      if (cmd_i.store_item && !item_i.no_byte) begin
        if (count_q < 6'(MaxBytes)) begin
          count_q <= count_q + 6'd1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.clear_msg) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    load_pos_q <= cmd_i.step;
    if (load_act_q) begin
      w_q[load_pos_q[5:2]] <= {w_q[load_pos_q[5:2]][23:0], pad_byte};
    end
    if (cmd_i.init_vars) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= InitH[i];
      end
    end
    if (cmd_i.do_round) begin
      w_q[slot] <= wcur;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (cmd_i.emit_word) begin
      result_o.digest_word <= InitH[cmd_i.step[2:0]] + v_q[cmd_i.step[2:0]];
      result_o.word_index  <= cmd_i.step[2:0];
      result_o.last_word   <= (cmd_i.step[2:0] == 3'd7);
      result_o.too_long    <= ovf_q;
    end
  end
endmodule

[sv/sha256_single_block_hash.sv]
// Top level: single-block SHA-256 hasher.
// Bytes: one item per cycle while busy is low.
// A last item starts the load of all 64 block bytes (one message RAM read per byte),
// the init of the working variables and the 64 rounds (one shared round unit),
// then 8 digest words.
// Reset (rst_ni low, asynchronous) clears the controller, byte count and flags.
module sha256_single_block_hash
  import sha256_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  sha_in_t  item_i,
  output logic     result_valid_o,
  output sha_out_t result_o
);
  sha_cmd_t cmd;

  sha256_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .item_i  (item_i),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  sha256_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.last) |=> busy)
    else $error("busy not raised after last item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy || result_o.last_word)
    else $error("digest word outside a run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_word) |=> !result_valid_o)
    else $error("word after last digest word");
endmodule
